// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the threshold record codec.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition against a consequence in the same cycle.
`define TRC_ASSERT_SAME(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Check a condition against a consequence in the following cycle.
`define TRC_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/trc_pkg.sv =====
// Package of the threshold record codec: codes, threshold table, request
// and result types. No dependencies.
package trc_pkg;

    localparam int CHANNELS = 5;
    localparam int CH_W     = $clog2(CHANNELS);
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GROUP_A = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GROUP_B = 1'd1;

    localparam logic [7:0] GROUP_A_RESET = 8'd230;
    localparam logic [7:0] GROUP_B_RESET = 8'd231;

    typedef enum logic [1:0] {
        ACT_DECODE = 2'd0,
        ACT_UPDATE = 2'd1,
        ACT_BUNDLE = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_TAKEN     = 3'd0,
        ST_COMMITTED = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_ENCODED   = 3'd3,
        ST_DENIED    = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  command;
        logic [7:0]  selector;
        logic [7:0]  enabled;
        logic [15:0] value;
        logic        last_record;
        logic [2:0]  channel;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  command;
        logic [7:0]  selector;
        logic        enabled;
        logic [15:0] value;
        logic        last;
    } result_t;

    // Results caused by one request, slot 0 first
    typedef struct packed {
        logic [1:0]    count;
        result_t [2:0] res;
    } res_group_t;

    // Threshold table: group, selector byte and allowed value range
    function automatic logic tbl_group_b(input logic [CH_W-1:0] e);
        logic g;
        case (e)
            3'd2, 3'd3, 3'd4: g = 1'b1;
            default:          g = 1'b0;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] tbl_sel(input logic [CH_W-1:0] e);
        logic [7:0] s;
        case (e)
            3'd0:    s = 8'h05;
            3'd1:    s = 8'h07;
            3'd2:    s = 8'h01;
            3'd3:    s = 8'h03;
            3'd4:    s = 8'h04;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] tbl_min(input logic [CH_W-1:0] e);
        logic [15:0] m;
        case (e)
            3'd0:    m = 16'd40;
            3'd1:    m = 16'd1;
            3'd2:    m = 16'd1;
            3'd3:    m = 16'd90;
            3'd4:    m = 16'd75;
            default: m = 16'd0;
        endcase
        return m;
    endfunction

    function automatic logic [15:0] tbl_max(input logic [CH_W-1:0] e);
        logic [15:0] m;
        case (e)
            3'd0:    m = 16'd100;
            3'd1:    m = 16'd26;
            3'd2:    m = 16'd65;
            3'd3:    m = 16'd265;
            3'd4:    m = 16'd240;
            default: m = 16'd0;
        endcase
        return m;
    endfunction

    // Entry exists, enable byte is 0 or 1, value inside the entry's range
    function automatic logic in_range(input logic [CH_W-1:0] e, input logic [7:0] en,
                                      input logic [15:0] v);
        return (32'(e) < CHANNELS) && (en <= 8'd1)
            && (v >= tbl_min(e)) && (v <= tbl_max(e));
    endfunction

endpackage

// ===== rtl/trc_req_if.sv =====
// Request channel of the threshold record codec: valid/ready plus one record.
// Standalone; no package needed.
interface trc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  command;
    logic [7:0]  selector;
    logic [7:0]  enabled;
    logic [15:0] value;
    logic        last_record;
    logic [2:0]  channel;

    modport source (
        output valid, action, command, selector, enabled, value, last_record, channel,
        input  ready
    );
    modport sink (
        input  valid, action, command, selector, enabled, value, last_record, channel,
        output ready
    );
endinterface

// ===== rtl/trc_res_if.sv =====
// Result channel of the threshold record codec: valid/ready plus one result.
// Standalone; no package needed.
interface trc_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  out_command;
    logic [7:0]  out_selector;
    logic        out_enabled;
    logic [15:0] out_value;
    logic        out_last;

    modport source (
        output valid, status, out_command, out_selector, out_enabled, out_value, out_last,
        input  ready
    );
    modport sink (
        input  valid, status, out_command, out_selector, out_enabled, out_value, out_last,
        output ready
    );
endinterface

// ===== rtl/trc_core.sv =====
// Threshold store, decode frame state and result generation of the codec.
// Depends on trc_pkg.
module trc_core
    import trc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   req_fire,
    input  req_t                   req,
    output res_group_t             res_group
);

    logic [7:0]          group_a_reg, group_a_next;
    logic [7:0]          group_b_reg, group_b_next;
    logic [15:0]         committed_value_reg [CHANNELS];
    logic [15:0]         committed_value_next [CHANNELS];
    logic [CHANNELS-1:0] committed_enable_reg, committed_enable_next;
    logic [CHANNELS-1:0] committed_known_reg, committed_known_next;
    logic [15:0]         staged_value_reg [CHANNELS];
    logic [15:0]         staged_value_next [CHANNELS];
    logic [CHANNELS-1:0] staged_enable_reg, staged_enable_next;
    logic [CHANNELS-1:0] staged_known_reg, staged_known_next;
    logic [CHANNELS-1:0] seen_mask_reg, seen_mask_next;
    logic [1:0]          record_count_reg, record_count_next;
    logic                frame_error_reg, frame_error_next;
    logic                frame_open_reg, frame_open_next;
    logic [7:0]          frame_command_reg, frame_command_next;

    // Working copy of the frame for the current decode record
    logic [7:0]          frame_cmd;
    logic [15:0]         st_value [CHANNELS];
    logic [CHANNELS-1:0] st_enable;
    logic [CHANNELS-1:0] st_known;
    logic [CHANNELS-1:0] seen;
    logic [1:0]          cnt;
    logic                err;
    logic [1:0]          limit;
    logic                hit;
    logic [CH_W-1:0]     hit_idx;
    logic                bad;
    logic [CHANNELS-1:0] entry_ok;
    logic                update_ok;
    logic                bundle_a;
    logic                bundle_b;

    // Decode: pick frame context, match table, check and stage the record
    always_comb
    begin
        if (frame_open_reg)
        begin
            frame_cmd = frame_command_reg;
            st_value  = staged_value_reg;
            st_enable = staged_enable_reg;
            st_known  = staged_known_reg;
            seen      = seen_mask_reg;
            cnt       = record_count_reg;
            err       = frame_error_reg;
        end
        else
        begin
            frame_cmd = req.command;
            st_value  = committed_value_reg;
            st_enable = committed_enable_reg;
            st_known  = committed_known_reg;
            seen      = '0;
            cnt       = '0;
            err       = 1'b0;
        end

        if (frame_cmd == group_a_reg)
            limit = 2'd2;
        else if (frame_cmd == group_b_reg)
            limit = 2'd3;
        else
            limit = 2'd0;

        // Lowest matching entry wins
        hit     = 1'b0;
        hit_idx = '0;
        for (int e = CHANNELS - 1; e >= 0; e--)
        begin
            if ((tbl_group_b(CH_W'(e)) ? group_b_reg : group_a_reg) == frame_cmd
                && tbl_sel(CH_W'(e)) == req.selector)
            begin
                hit     = 1'b1;
                hit_idx = CH_W'(e);
            end
        end

        bad = (cnt >= limit) || !hit || seen[hit_idx]
            || !in_range(hit_idx, req.enabled, req.value);

        if (limit == 2'd0)
            err = 1'b1;
        if (!err)
        begin
            if (bad)
                err = 1'b1;
            else
            begin
                seen[hit_idx]      = 1'b1;
                st_value[hit_idx]  = req.value;
                st_enable[hit_idx] = req.enabled[0];
                st_known[hit_idx]  = 1'b1;
            end
        end

        if (cnt != 2'd3)
            cnt = cnt + 2'd1;
    end

    // Encode checks against the committed thresholds
    always_comb
    begin
        for (int e = 0; e < CHANNELS; e++)
        begin
            entry_ok[e] = committed_known_reg[e]
                && in_range(CH_W'(e), {7'd0, committed_enable_reg[e]},
                            committed_value_reg[e]);
        end
        update_ok = (32'(req.channel) < CHANNELS) && committed_known_reg[req.channel]
            && in_range(req.channel, req.enabled, req.value);
        bundle_a = req.command == group_a_reg;
        bundle_b = !bundle_a && (req.command == group_b_reg);
    end

    // Build results and next state for the request
    always_comb
    begin
        group_a_next          = group_a_reg;
        group_b_next          = group_b_reg;
        committed_value_next  = committed_value_reg;
        committed_enable_next = committed_enable_reg;
        committed_known_next  = committed_known_reg;
        staged_value_next     = staged_value_reg;
        staged_enable_next    = staged_enable_reg;
        staged_known_next     = staged_known_reg;
        seen_mask_next        = seen_mask_reg;
        record_count_next     = record_count_reg;
        frame_error_next      = frame_error_reg;
        frame_open_next       = frame_open_reg;
        frame_command_next    = frame_command_reg;

        res_group            = '0;
        res_group.count      = 2'd1;
        res_group.res[0]     = '0;
        res_group.res[0].status = ST_DENIED;
        res_group.res[0].last   = 1'b1;

        case (req.action)
            ACT_DECODE:
            begin
                if (req.last_record)
                    res_group.res[0].status = err ? ST_REJECTED : ST_COMMITTED;
                else
                    res_group.res[0].status = ST_TAKEN;
                if (req_fire)
                begin
                    staged_value_next  = st_value;
                    staged_enable_next = st_enable;
                    staged_known_next  = st_known;
                    seen_mask_next     = seen;
                    record_count_next  = cnt;
                    frame_error_next   = err;
                    frame_command_next = frame_cmd;
                    frame_open_next    = !req.last_record;
                    if (req.last_record && !err)
                    begin
                        committed_value_next  = st_value;
                        committed_enable_next = st_enable;
                        committed_known_next  = st_known;
                    end
                end
            end
            ACT_UPDATE:
            begin
                if (update_ok)
                begin
                    res_group.res[0].status   = ST_ENCODED;
                    res_group.res[0].command  = tbl_group_b(req.channel) ? group_b_reg
                                                                         : group_a_reg;
                    res_group.res[0].selector = tbl_sel(req.channel);
                    res_group.res[0].enabled  = req.enabled[0];
                    res_group.res[0].value    = req.value;
                end
            end
            ACT_BUNDLE:
            begin
                if (bundle_a && entry_ok[0] && entry_ok[1])
                begin
                    res_group.count = 2'd2;
                    for (int i = 0; i < 2; i++)
                    begin
                        res_group.res[i].status   = ST_ENCODED;
                        res_group.res[i].command  = req.command;
                        res_group.res[i].selector = tbl_sel(CH_W'(i));
                        res_group.res[i].enabled  = committed_enable_reg[i];
                        res_group.res[i].value    = committed_value_reg[i];
                        res_group.res[i].last     = (i == 1);
                    end
                end
                else if (bundle_b && entry_ok[2] && entry_ok[3] && entry_ok[4])
                begin
                    res_group.count = 2'd3;
                    for (int i = 0; i < 3; i++)
                    begin
                        res_group.res[i].status   = ST_ENCODED;
                        res_group.res[i].command  = req.command;
                        res_group.res[i].selector = tbl_sel(CH_W'(i + 2));
                        res_group.res[i].enabled  = committed_enable_reg[i + 2];
                        res_group.res[i].value    = committed_value_reg[i + 2];
                        res_group.res[i].last     = (i == 2);
                    end
                end
            end
            default:
            begin
                res_group.res[0].status = ST_DENIED;
            end
        endcase

        // Configuration writes must arrive only while idle; the block itself does not enforce this.
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_GROUP_A: group_a_next = cfg_data;
                CFG_GROUP_B: group_b_next = cfg_data;
                default:     group_a_next = group_a_reg;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_a_reg          <= GROUP_A_RESET;
            group_b_reg          <= GROUP_B_RESET;
            committed_known_reg  <= '0;
            committed_enable_reg <= '0;
            staged_known_reg     <= '0;
            staged_enable_reg    <= '0;
            seen_mask_reg        <= '0;
            record_count_reg     <= '0;
            frame_error_reg      <= 1'b0;
            frame_open_reg       <= 1'b0;
            frame_command_reg    <= '0;
        end
        else
        begin
            group_a_reg          <= group_a_next;
            group_b_reg          <= group_b_next;
            committed_known_reg  <= committed_known_next;
            committed_enable_reg <= committed_enable_next;
            staged_known_reg     <= staged_known_next;
            staged_enable_reg    <= staged_enable_next;
            seen_mask_reg        <= seen_mask_next;
            record_count_reg     <= record_count_next;
            frame_error_reg      <= frame_error_next;
            frame_open_reg       <= frame_open_next;
            frame_command_reg    <= frame_command_next;
        end
    end

    // Threshold values; only read behind a known bit
    always_ff @(posedge clk)
    begin
        committed_value_reg <= committed_value_next;
        staged_value_reg    <= staged_value_next;
    end

endmodule

// ===== rtl/threshold_record_codec.sv =====
// Threshold record codec top level. A result appears in the cycle after its request is
// accepted. One request per cycle for single-result requests while results are taken;
// a bundle occupies the result register for its two or three results, one taken per cycle
// while result.ready is high, and the next request is accepted as its last result is taken.
// Reset (async, active low): thresholds unknown, no frame open, group commands 230 and
// 231, result register empty.
module threshold_record_codec
    import trc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    trc_req_if.sink                request,
    trc_res_if.source              result
);

    req_t       req;
    res_group_t res_group;
    logic       req_fire;
    logic       res_fire;

    result_t    queue_reg [3];
    result_t    queue_next [3];
    logic [1:0] count_reg, count_next;

    // Pack the request fields
    always_comb
    begin
        req.action      = request.action;
        req.command     = request.command;
        req.selector    = request.selector;
        req.enabled     = request.enabled;
        req.value       = request.value;
        req.last_record = request.last_record;
        req.channel     = request.channel;
    end

    // Accept when the result register frees up this cycle
    assign request.ready = (count_reg == 2'd0) || (count_reg == 2'd1 && result.ready);
    assign req_fire      = request.valid && request.ready;
    assign res_fire      = result.valid && result.ready;

    trc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_fire  (req_fire),
        .req       (req),
        .res_group (res_group)
    );

    // Load a new result group or advance to the next result
    always_comb
    begin
        queue_next = queue_reg;
        count_next = count_reg;
        if (req_fire)
        begin
            queue_next[0] = res_group.res[0];
            queue_next[1] = res_group.res[1];
            queue_next[2] = res_group.res[2];
            count_next    = res_group.count;
        end
        else if (res_fire)
        begin
            queue_next[0] = queue_reg[1];
            queue_next[1] = queue_reg[2];
            count_next    = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        queue_reg <= queue_next;
    end

    // Drive the head result
    assign result.valid        = count_reg != 2'd0;
    assign result.status       = queue_reg[0].status;
    assign result.out_command  = queue_reg[0].command;
    assign result.out_selector = queue_reg[0].selector;
    assign result.out_enabled  = queue_reg[0].enabled;
    assign result.out_value    = queue_reg[0].value;
    assign result.out_last     = queue_reg[0].last;

endmodule

// ===== rtl/trc_checker.sv =====
// Port-level checks of the threshold record codec, bound to the top level.
// Depends on trc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module trc_checker
    import trc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_status,
    input logic [7:0]  out_command,
    input logic [7:0]  out_selector,
    input logic        out_enabled,
    input logic [15:0] out_value,
    input logic        out_last
);

    // Hold a result until it is taken
    `TRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    // Follow a taken non-final result with the rest of its group
    `TRC_ASSERT_NEXT(a_group_cont, out_valid && out_ready && !out_last, out_valid, "result group broken off")
    // Take no request while a group is still being delivered
    `TRC_ASSERT_SAME(a_no_overlap, out_valid && !out_last, !(in_valid && in_ready), "request taken mid group")
    // Only encoded records come in groups
    `TRC_ASSERT_SAME(a_group_encoded, out_valid && !out_last, out_status == ST_ENCODED, "non-final result not encoded")
    // Zero record fields on status-only results
    `TRC_ASSERT_SAME(a_zero_fields, out_valid && out_status != ST_ENCODED, out_command == 8'd0 && out_selector == 8'd0 && !out_enabled && out_value == 16'd0, "record fields set on status result")

endmodule

bind threshold_record_codec trc_checker u_trc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (request.valid),
    .in_ready     (request.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_status   (result.status),
    .out_command  (result.out_command),
    .out_selector (result.out_selector),
    .out_enabled  (result.out_enabled),
    .out_value    (result.out_value),
    .out_last     (result.out_last)
);
